@@ sv/amar_pkg.sv @@
// Shared types and constants for the accelerometer moving-average report block.
// No dependencies; used by amar_cell and accel_moving_average_report_top.
package amar_pkg;

    localparam int WINDOW_LENGTH = 20;

    // index width of the window, at least one bit
    localparam int IDX_W = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
    // running sum spans -32*W .. 31*W
    localparam int SUM_W = 6 + IDX_W;
    // reciprocal of the window: floor(m * RECIP >> RECIP_SHIFT) == m / W for m < 2**SUM_W
    localparam int RECIP_SHIFT = SUM_W + IDX_W;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam longint RECIP   = ((64'd1 << RECIP_SHIFT) + WINDOW_LENGTH - 1) / WINDOW_LENGTH;

    localparam int AXIS_W = 6;
    localparam int FAIL_BIT  = 6;
    localparam int TAP_BIT   = 5;
    localparam int SHAKE_BIT = 7;

    // raw orientation codes (tilt bits 4..2)
    localparam logic [2:0] RAW_LEFT  = 3'd1;
    localparam logic [2:0] RAW_RIGHT = 3'd2;
    localparam logic [2:0] RAW_DOWN  = 3'd5;
    localparam logic [2:0] RAW_UP    = 3'd6;

    // reported orientation codes
    localparam logic [2:0] ORI_UNKNOWN = 3'd0;
    localparam logic [2:0] ORI_LEFT    = 3'd1;
    localparam logic [2:0] ORI_RIGHT   = 3'd2;
    localparam logic [2:0] ORI_DOWN    = 3'd3;
    localparam logic [2:0] ORI_UP      = 3'd4;

    typedef logic signed [AXIS_W-1:0] t_axis;

    typedef struct packed {
        t_axis z;
        t_axis y;
        t_axis x;
    } t_sample;

endpackage

@@ sv/amar_cell.sv @@
// One window cell: holds one converted sample and passes it to the next cell
// on every accepted transaction. Depends on amar_pkg.
module amar_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_shift,
    input  amar_pkg::t_sample i_sample,
    output amar_pkg::t_sample o_sample
);

    amar_pkg::t_sample r_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
        end else if (i_shift) begin
            r_sample <= i_sample;
        end
    end

    assign o_sample = r_sample;

endmodule

@@ sv/accel_moving_average_report_top.sv @@
// Accelerometer moving-average report: a chain of WINDOW_LENGTH cells forms the window.
// Reports pass report stage, then output register; one sample per cycle unless stalled.
// Samples that cause no report produce no output transaction.
// Synchronous active-low reset clears the window, sums, index and last reported tilt.
// The output register and the stage before it decouple stalls on the master side.
// Depends on amar_pkg and amar_cell.
module accel_moving_average_report_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // x_raw[7:0], y_raw[15:8], z_raw[23:16], tilt_status[31:24]
    input  logic [31:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // avg_x[5:0], avg_y[11:6], avg_z[17:12], orientation[20:18],
    // tap_seen[21], shake_seen[22], zero[23]
    output logic [23:0] o_m_axis_tdata
);

    localparam int W = amar_pkg::WINDOW_LENGTH;
    localparam int SW = amar_pkg::SUM_W;

    function automatic amar_pkg::t_axis div_window(input logic signed [SW-1:0] s);
        logic                                  neg;
        logic [SW-1:0]                         mag;
        logic [SW+amar_pkg::RECIP_W-1:0]       prod;
        logic [SW-1:0]                         q;
        neg  = s[SW-1];
        mag  = neg ? (~s + SW'(1)) : s;
        prod = mag * amar_pkg::RECIP_W'(amar_pkg::RECIP);
        q    = SW'(prod >> amar_pkg::RECIP_SHIFT);
        if (neg) begin
            q = ~q + SW'(1);
        end
        return amar_pkg::t_axis'(q[amar_pkg::AXIS_W-1:0]);
    endfunction

    function automatic logic [2:0] orient_code(input logic [7:0] tilt);
        logic [2:0] o;
        unique case (tilt[4:2])
            amar_pkg::RAW_LEFT:  o = amar_pkg::ORI_LEFT;
            amar_pkg::RAW_RIGHT: o = amar_pkg::ORI_RIGHT;
            amar_pkg::RAW_DOWN:  o = amar_pkg::ORI_DOWN;
            amar_pkg::RAW_UP:    o = amar_pkg::ORI_UP;
            default:             o = amar_pkg::ORI_UNKNOWN;
        endcase
        return o;
    endfunction

    logic [7:0] w_x_raw, w_y_raw, w_z_raw, w_tilt;
    logic       w_accept;
    logic       w_report;
    logic       w_s2_load;

    amar_pkg::t_sample w_chain [W];
    amar_pkg::t_sample w_tail;
    amar_pkg::t_sample n_head;

    logic [amar_pkg::IDX_W-1:0] r_idx;
    logic signed [SW-1:0]       r_sum_x, r_sum_y, r_sum_z;
    logic signed [SW-1:0]       n_sum_x, n_sum_y, n_sum_z;
    logic [7:0]                 r_last_tilt;

    logic                       r_s1_valid;
    logic signed [SW-1:0]       r_s1_sum_x, r_s1_sum_y, r_s1_sum_z;
    logic [7:0]                 r_s1_tilt;

    logic                       r_o_valid;
    logic [23:0]                r_o_data;

    assign w_x_raw = i_s_axis_tdata[7:0];
    assign w_y_raw = i_s_axis_tdata[15:8];
    assign w_z_raw = i_s_axis_tdata[23:16];
    assign w_tilt  = i_s_axis_tdata[31:24];

    assign w_s2_load       = r_s1_valid && (!r_o_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_valid || w_s2_load;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // oldest sample leaves at the tail; a failed axis repeats the tail value, so its sum holds
    assign w_tail = w_chain[W-1];

    always_comb begin
        n_head.x = w_x_raw[amar_pkg::FAIL_BIT] ? w_tail.x : amar_pkg::t_axis'(w_x_raw[5:0]);
        n_head.y = w_y_raw[amar_pkg::FAIL_BIT] ? w_tail.y : amar_pkg::t_axis'(w_y_raw[5:0]);
        n_head.z = w_z_raw[amar_pkg::FAIL_BIT] ? w_tail.z : amar_pkg::t_axis'(w_z_raw[5:0]);
        n_sum_x  = r_sum_x - SW'(w_tail.x) + SW'(n_head.x);
        n_sum_y  = r_sum_y - SW'(w_tail.y) + SW'(n_head.y);
        n_sum_z  = r_sum_z - SW'(w_tail.z) + SW'(n_head.z);
    end

    genvar g;
    generate
        for (g = 0; g < W; g++) begin : g_cell
            amar_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_shift  (w_accept),
                .i_sample ((g == 0) ? n_head : w_chain[(g == 0) ? 0 : g - 1]),
                .o_sample (w_chain[g])
            );
        end
    endgenerate

    assign w_report = (r_idx == amar_pkg::IDX_W'(W - 1)) ||
                      ((r_last_tilt != 8'd0) && (r_last_tilt != w_tilt));

    // window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_sum_z     <= '0;
            r_last_tilt <= '0;
        end else if (w_accept) begin
            r_idx   <= (r_idx == amar_pkg::IDX_W'(W - 1)) ? '0 : r_idx + 1'b1;
            r_sum_x <= n_sum_x;
            r_sum_y <= n_sum_y;
            r_sum_z <= n_sum_z;
            if (w_report) begin
                r_last_tilt <= w_tilt;
            end
        end
    end

    // report stage: hold sums and tilt of a reporting sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= w_report;
        end else if (w_s2_load) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_sum_x <= n_sum_x;
            r_s1_sum_y <= n_sum_y;
            r_s1_sum_z <= n_sum_z;
            r_s1_tilt  <= w_tilt;
        end
    end

    // output register: divide by the window and pack the report
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_s2_load) begin
            r_o_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_load) begin
            r_o_data <= {1'b0,
                         r_s1_tilt[amar_pkg::SHAKE_BIT],
                         r_s1_tilt[amar_pkg::TAP_BIT],
                         orient_code(r_s1_tilt),
                         div_window(r_s1_sum_z),
                         div_window(r_s1_sum_y),
                         div_window(r_s1_sum_x)};
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;

endmodule
